[rtl/rsmp_pkg.sv]
package rsmp_pkg;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_COEF   = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] sample;
    logic [9:0]         coef_addr;
    logic signed [31:0] coef_value;
  } item_t;

  typedef struct packed {
    logic [4:0]        phases;
    logic signed [8:0] phase_step;
    logic [6:0]        taps;
    logic              sample_mode;
  } cfg_t;

  localparam int COEF_Q     = 26;
  localparam int HALF_BITS  = 16;
  localparam int MAX_OUT    = 16;
  localparam int WAIT_FLOOR = -256;
  localparam int MAG_W      = 9;
  localparam int TGT_W      = 11;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 9;
  localparam logic [CFG_IW-1:0] REG_PHASES      = 2'd0;
  localparam logic [CFG_IW-1:0] REG_PHASE_STEP  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_TAPS        = 2'd2;
  localparam logic [CFG_IW-1:0] REG_SAMPLE_MODE = 2'd3;

endpackage

[rtl/rsmp_front.sv]
module rsmp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_tuser,
  input  logic [79:0]          in_tdata,
  output logic                 q_valid,
  output rsmp_pkg::item_t      q_item,
  input  logic                 q_pop
);
  import rsmp_pkg::*;

  item_t       fifo_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  item_t       item_in;
  logic        push, pop;

  always_comb begin
    item_in.kind       = in_tuser ? KIND_COEF : KIND_SAMPLE;
    item_in.sample     = in_tdata[31:0];
    item_in.coef_addr  = in_tdata[41:32];
    item_in.coef_value = in_tdata[73:42];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = fifo_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

[rtl/rsmp_engine.sv]
module rsmp_engine #(
  parameter int MAX_PHASES = 16,
  parameter int MAX_TAPS   = 64,
  parameter int COEF_DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rsmp_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  rsmp_pkg::item_t  q_item,
  output logic             q_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,
  output logic             out_tlast
);
  import rsmp_pkg::*;

  localparam int NW   = $clog2(MAX_PHASES + 1);
  localparam int TFW  = $clog2(MAX_TAPS + 1);
  localparam int HPW  = $clog2(MAX_TAPS);
  localparam int AW   = $clog2(COEF_DEPTH);
  localparam int EW   = (AW + 1 > 10) ? AW + 1 : 10;
  localparam int CIW  = $clog2(MAX_PHASES * (MAX_TAPS + 2) + COEF_DEPTH);
  localparam int HIW  = TGT_W + TFW;
  localparam int CW   = MAG_W + 1;
  localparam int DCW  = $clog2(MAG_W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_CHECK,
    S_MAC
  } state_t;

  state_t               state_r;
  logic [31:0]          coef_mem [COEF_DEPTH];
  logic [31:0]          hist_mem [MAX_TAPS];

  logic signed [NW:0]   pa_r;
  logic signed [TGT_W-1:0] stw_r;
  logic [HPW-1:0]       wp_r;
  logic [TFW-1:0]       fill_r;
  logic [4:0]           cnt_r;

  logic [MAG_W-1:0]     dnd_r, quo_r;
  logic [NW:0]          rem_r;
  logic                 neg_r;
  logic [DCW-1:0]       dstep_r;

  logic [HIW-1:0]       base_r;
  logic [TFW-1:0]       j_r;
  logic [CIW-1:0]       ci_r;
  logic                 v1_r, v2_r;
  logic [31:0]          coef_rd_r, hist_rd_r;
  logic signed [63:0]   prod_r;
  logic [63:0]          acc_r;

  logic                 pend_r;
  logic [31:0]          pend_val_r;
  logic                 out_valid_r;
  logic [31:0]          out_data_r;
  logic                 out_last_r;

  logic [NW-1:0]        n;
  logic [TFW-1:0]       t;
  logic signed [CW-1:0] cand;
  logic [NW:0]          rem_sh, rem_sub;
  logic                 qbit;
  logic signed [TGT_W-1:0] q_s, tgt, tgt_p1, stw_m1, sat_tp1, sat_m1;
  logic signed [NW:0]   r_s;
  logic                 stop, out_free;
  logic                 issue, tap_ok;
  logic [HIW-1:0]       hi;
  logic signed [HPW+1:0] hd;
  logic [HPW-1:0]       haddr;
  logic [AW-1:0]        caddr;
  logic [EW-1:0]        waddr_ext;
  logic signed [31:0]   s_op;
  logic [31:0]          res_val;
  logic                 mac_done;
  logic                 hist_we, coef_we;

  // Clamp the branch and tap counts to the supported range.
  always_comb begin
    if (cfg.phases == 5'd0) n = NW'(1);
    else if (32'(cfg.phases) > MAX_PHASES) n = NW'(MAX_PHASES);
    else n = NW'(cfg.phases);
    if (cfg.taps == 7'd0) t = TFW'(1);
    else if (32'(cfg.taps) > MAX_TAPS) t = TFW'(MAX_TAPS);
    else t = TFW'(cfg.taps);
  end

  assign cand = CW'(pa_r) + CW'(cfg.phase_step);

  always_comb begin
    rem_sh  = {rem_r[NW-1:0], dnd_r[MAG_W-1]};
    qbit    = (rem_sh >= (NW+1)'(n));
    rem_sub = qbit ? rem_sh - (NW+1)'(n) : rem_sh;
  end

  // Truncating division: quotient and remainder take the dividend's sign.
  always_comb begin
    q_s    = neg_r ? -TGT_W'(quo_r) : TGT_W'(quo_r);
    r_s    = neg_r ? -$signed(rem_r) : $signed(rem_r);
    tgt    = stw_r + q_s;
    tgt_p1 = tgt + TGT_W'(1);
    stw_m1 = stw_r - TGT_W'(1);
    sat_tp1 = (tgt_p1 < TGT_W'(WAIT_FLOOR)) ? TGT_W'(WAIT_FLOOR) : tgt_p1;
    sat_m1  = (stw_m1 < TGT_W'(WAIT_FLOOR)) ? TGT_W'(WAIT_FLOOR) : stw_m1;
    stop   = (tgt > TGT_W'(0)) || (cnt_r == 5'(MAX_OUT));
    out_free = !out_valid_r || out_tready;
  end

  // Tap address generation: history is a circular buffer, newest at wp-1.
  always_comb begin
    issue  = (state_r == S_MAC) && (j_r < t);
    hi     = base_r + HIW'(j_r);
    tap_ok = (hi < HIW'(fill_r)) && (ci_r < CIW'(COEF_DEPTH));
    hd     = (HPW+2)'(wp_r) - (HPW+2)'(1) - (HPW+2)'(hi[HPW:0]);
    if (hd < 0) hd = hd + (HPW+2)'(MAX_TAPS);
    haddr  = hd[HPW-1:0];
    caddr  = ci_r[AW-1:0];
    s_op   = cfg.sample_mode ? 32'($signed(hist_rd_r[15:0])) : $signed(hist_rd_r);
    res_val = cfg.sample_mode ? 32'($signed(acc_r[COEF_Q+HALF_BITS-1:COEF_Q]))
                              : acc_r[COEF_Q+31:COEF_Q];
    mac_done = (state_r == S_MAC) && !issue && !v1_r && !v2_r;
    waddr_ext = EW'(q_item.coef_addr);
    q_pop   = (state_r == S_IDLE) && q_valid;
    hist_we = q_pop && (q_item.kind == KIND_SAMPLE);
    coef_we = q_pop && (q_item.kind == KIND_COEF) && (waddr_ext < EW'(COEF_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[wp_r] <= q_item.sample;
    end
    if (coef_we) begin
      coef_mem[waddr_ext[AW-1:0]] <= q_item.coef_value;
    end
    hist_rd_r <= hist_mem[haddr];
    coef_rd_r <= coef_mem[caddr];
    prod_r    <= s_op * $signed(coef_rd_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pa_r        <= '0;
      stw_r       <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      cnt_r       <= '0;
      dstep_r     <= '0;
      j_r         <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      v1_r <= issue && tap_ok;
      v2_r <= v1_r;
      if (v2_r) begin
        acc_r <= acc_r + prod_r;
      end
      case (state_r)
        S_IDLE: begin
          if (hist_we) begin
            wp_r    <= (32'(wp_r) == MAX_TAPS - 1) ? '0 : wp_r + HPW'(1);
            if (32'(fill_r) < MAX_TAPS) fill_r <= fill_r + TFW'(1);
            cnt_r   <= '0;
            state_r <= S_START;
          end
        end
        S_START: begin
          neg_r   <= cand < 0;
          dnd_r   <= (cand < 0) ? MAG_W'(-cand) : MAG_W'(cand);
          rem_r   <= '0;
          quo_r   <= '0;
          dstep_r <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r   <= rem_sub;
          quo_r   <= {quo_r[MAG_W-2:0], qbit};
          dnd_r   <= {dnd_r[MAG_W-2:0], 1'b0};
          dstep_r <= dstep_r + DCW'(1);
          if (32'(dstep_r) == MAG_W - 1) state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (!pend_r || out_free) begin
            if (pend_r) begin
              out_valid_r <= 1'b1;
              out_data_r  <= pend_val_r;
              out_last_r  <= stop;
              pend_r      <= 1'b0;
            end
            if (stop) begin
              stw_r   <= sat_m1;
              state_r <= S_IDLE;
            end else begin
              pa_r    <= r_s;
              stw_r   <= sat_tp1;
              base_r  <= HIW'(-tgt);
              cnt_r   <= cnt_r + 5'd1;
              j_r     <= '0;
              ci_r    <= CIW'(r_s + $signed((NW+1)'(n)));
              acc_r   <= '0;
              state_r <= S_MAC;
            end
          end
        end
        S_MAC: begin
          if (issue) begin
            j_r  <= j_r + TFW'(1);
            ci_r <= ci_r + CIW'(n);
          end
          if (mac_done) begin
            pend_r     <= 1'b1;
            pend_val_r <= res_val;
            state_r    <= S_START;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

[rtl/polyphase_rational_resampler.sv]
// Rational polyphase FIR resampler. Requests with tuser high write one Q26
// coefficient; requests with tuser low push one sample into a MAX_TAPS deep
// history and produce every output that sample completes (at most 16, the
// final one flagged by tlast). Each output takes one multiply-accumulate per
// tap through a single 32x32 multiplier fed by the coefficient and history
// memories, plus a nine-step phase divider. The engine takes no new request
// until a push has produced all its outputs, and waits while the result side
// holds off; a coefficient write does not start it. A two-entry request
// queue and an output register let both sides stall independently.
// Coefficients are undefined until written.
module polyphase_rational_resampler #(
  parameter int MAX_PHASES = 16,
  parameter int MAX_TAPS   = 64,
  parameter int COEF_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic                          in_tuser,   // action
  input  logic [79:0]                   in_tdata,   // sample_in, coef_addr, coef_value
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // sample_out
  output logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic [rsmp_pkg::CFG_IW-1:0]   cfg_addr,
  input  logic [rsmp_pkg::CFG_DW-1:0]   cfg_wdata
);
  import rsmp_pkg::*;

  cfg_t  cfg_r;
  logic  q_valid, q_pop;
  item_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phases      <= 5'd1;
      cfg_r.phase_step  <= '0;
      cfg_r.taps        <= 7'd1;
      cfg_r.sample_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PHASES:      cfg_r.phases      <= cfg_wdata[4:0];
        REG_PHASE_STEP:  cfg_r.phase_step  <= cfg_wdata[8:0];
        REG_TAPS:        cfg_r.taps        <= cfg_wdata[6:0];
        REG_SAMPLE_MODE: cfg_r.sample_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  rsmp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  rsmp_engine #(
    .MAX_PHASES (MAX_PHASES),
    .MAX_TAPS   (MAX_TAPS),
    .COEF_DEPTH (COEF_DEPTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
